[rtl/lfas_pkg.sv]
package lfas_pkg;

	localparam int CH_REG_W     = 13;
	localparam int NODE_REG_W   = 11;
	localparam int LEVEL_W      = 8;
	localparam int BRIGHT_W     = 9;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 13;
	localparam int TDATA_W      = 160;

	localparam int CH_REG_MAX   = 2 ** CH_REG_W - 1;
	localparam int NODE_REG_MAX = 2 ** NODE_REG_W - 1;
	localparam int MAX_MODE_CPN = 3;

	localparam logic [BRIGHT_W:0] BRIGHT_SAT = 10'd510;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT        = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_PER_NODE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THRESHOLD  = 8'd3;

	typedef struct packed {
		logic [CH_REG_W-1:0]   channel_count;
		logic [NODE_REG_W-1:0] node_count;
		logic [CH_REG_W-1:0]   channels_per_node;
		logic [LEVEL_W-1:0]    active_threshold;
	} cfg_t;

	typedef struct packed {
		logic                  restart;
		logic                  last;
		logic                  close;
		logic                  act_ch;
		logic                  act_node;
		logic                  cmp;
		logic                  chg_valid;
		logic [LEVEL_W-1:0]    level;
		logic [BRIGHT_W-1:0]   b;
		logic [NODE_REG_W-1:0] idx;
	} ev_t;

	typedef struct packed {
		logic [12:0] act_ch;
		logic [10:0] act_nodes;
		logic [19:0] lsum;
		logic [7:0]  lmax;
		logic [18:0] bsum;
		logic [9:0]  runs;
		logic [10:0] longest;
		logic [28:0] wsum;
		logic [18:0] wtsum;
		logic [18:0] chg;
	} acc_t;

endpackage

[rtl/lfas_prev_mem.sv]
module lfas_prev_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [lfas_pkg::BRIGHT_W-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [lfas_pkg::BRIGHT_W-1:0] wr_data
);

	logic [lfas_pkg::BRIGHT_W-1:0] mem [DEPTH];
	logic [lfas_pkg::BRIGHT_W-1:0] mem_q;
	logic [lfas_pkg::BRIGHT_W-1:0] byp_q;
	logic                          hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? byp_q : mem_q;

`ifndef ASSERT_OFF
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
		else $error("write-read collision not forwarded");
`endif

endmodule

[rtl/lfas_node.sv]
module lfas_node #(
	parameter int MAX_CHANNELS = 4096,
	parameter int MAX_NODES    = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [lfas_pkg::LEVEL_W-1:0] level,
	input  logic                         new_window,
	input  lfas_pkg::cfg_t               cfg,
	output lfas_pkg::ev_t                ev
);

	localparam int CCAP = (MAX_CHANNELS < lfas_pkg::CH_REG_MAX) ? MAX_CHANNELS
		: lfas_pkg::CH_REG_MAX;
	localparam int NCAP = (MAX_NODES < lfas_pkg::NODE_REG_MAX) ? MAX_NODES
		: lfas_pkg::NODE_REG_MAX;
	localparam int CW = $clog2(CCAP + 1);
	localparam int PW = (CCAP > 1) ? $clog2(CCAP) : 1;

	logic [PW-1:0]                   pos_q, pos_b;
	logic [CW-1:0]                   pin_q, pin_b, pin_n, pos_inc, cc_eff;
	logic [lfas_pkg::NODE_REG_W-1:0] idx_q, idx_b, idx_n, prev_q, nc_eff;
	logic [lfas_pkg::BRIGHT_W-1:0]   acc_q, acc_b, acc_n, b;
	logic [lfas_pkg::BRIGHT_W:0]     sum, bsel;
	logic [lfas_pkg::CH_REG_W-1:0]   cc_raw, cpn_eff;
	logic                            have_q, have_b;
	logic                            max_mode, in_node, last, close;

	always_comb begin
		cc_raw   = (cfg.channel_count == '0) ? 13'd1 : cfg.channel_count;
		cc_eff   = (cc_raw > 13'(CCAP)) ? CW'(CCAP) : CW'(cc_raw);
		nc_eff   = (cfg.node_count > 11'(NCAP)) ? 11'(NCAP) : cfg.node_count;
		cpn_eff  = (cfg.channels_per_node == '0) ? 13'd1 : cfg.channels_per_node;
		max_mode = cpn_eff >= 13'(lfas_pkg::MAX_MODE_CPN);

		pos_b  = new_window ? '0 : pos_q;
		pin_b  = new_window ? '0 : pin_q;
		idx_b  = new_window ? '0 : idx_q;
		acc_b  = new_window ? '0 : acc_q;
		have_b = new_window ? 1'b0 : have_q;

		pos_inc = CW'(pos_b) + CW'(1);
		last    = pos_inc >= cc_eff;
		in_node = idx_b < nc_eff;

		sum = {1'b0, acc_b} + {2'b00, level};
		if (max_mode) begin
			acc_n = ({1'b0, level} > acc_b) ? {1'b0, level} : acc_b;
		end else begin
			acc_n = (sum > lfas_pkg::BRIGHT_SAT) ? lfas_pkg::BRIGHT_SAT[8:0] : sum[8:0];
		end
		pin_n = pin_b + CW'(1);
		close = in_node && ((13'(pin_n) >= cpn_eff) || last);

		bsel = (max_mode || pin_n == CW'(1)) ? {acc_n, 1'b0} : {1'b0, acc_n};
		b    = (bsel > lfas_pkg::BRIGHT_SAT) ? lfas_pkg::BRIGHT_SAT[8:0] : bsel[8:0];

		idx_n = idx_b + {10'd0, close};

		ev.restart   = new_window;
		ev.last      = last;
		ev.close     = close;
		ev.act_ch    = level > cfg.active_threshold;
		ev.act_node  = b > {cfg.active_threshold, 1'b0};
		ev.cmp       = have_b && (idx_b < prev_q);
		ev.chg_valid = have_b && (prev_q == idx_n);
		ev.level     = level;
		ev.b         = b;
		ev.idx       = idx_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pin_q  <= '0;
			idx_q  <= '0;
			acc_q  <= '0;
			prev_q <= '0;
			have_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				pos_q  <= '0;
				pin_q  <= '0;
				idx_q  <= '0;
				acc_q  <= '0;
				prev_q <= idx_n;
				have_q <= idx_n != '0;
			end else begin
				pos_q  <= PW'(pos_inc);
				idx_q  <= idx_n;
				have_q <= have_b;
				if (close) begin
					pin_q <= '0;
					acc_q <= '0;
				end else if (in_node) begin
					pin_q <= pin_n;
					acc_q <= acc_n;
				end else begin
					pin_q <= pin_b;
					acc_q <= acc_b;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_history: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ev.last |=> have_q == (prev_q != '0))
		else $error("frame history flag out of step with node count");
`endif

endmodule

[rtl/lfas_frame_acc.sv]
module lfas_frame_acc #(
	parameter int AW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_accept,
	input  lfas_pkg::ev_t                 ev,
	output logic                          s1_ready,
	input  logic [lfas_pkg::BRIGHT_W-1:0] prev_b,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [lfas_pkg::BRIGHT_W-1:0] wr_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lfas_pkg::TDATA_W-1:0]  m_tdata,
	output logic [0:0]                    m_tuser
);

	lfas_pkg::ev_t  ev_s1;
	logic           valid_s1;
	lfas_pkg::acc_t acc_q, acc_b, acc_n, res_n, out_q;
	logic [10:0]    run_q, run_b, run_n;
	logic           out_valid_q, out_cv_q;
	logic           out_free, s1_go;
	logic [19:0]    prod;
	logic [8:0]     diff;

	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!ev_s1.last || out_free);
	assign s1_ready = !valid_s1 || s1_go;

	assign wr_en   = s1_go && ev_s1.close;
	assign wr_addr = ev_s1.idx[AW-1:0];
	assign wr_data = ev_s1.b;

	always_comb begin
		acc_b = ev_s1.restart ? '0 : acc_q;
		run_b = ev_s1.restart ? '0 : run_q;
		prod  = {11'd0, ev_s1.b} * {9'd0, ev_s1.idx};
		diff  = (ev_s1.b > prev_b) ? ev_s1.b - prev_b : prev_b - ev_s1.b;

		acc_n        = acc_b;
		run_n        = run_b;
		acc_n.lsum   = acc_b.lsum + {12'd0, ev_s1.level};
		acc_n.lmax   = (ev_s1.level > acc_b.lmax) ? ev_s1.level : acc_b.lmax;
		acc_n.act_ch = acc_b.act_ch + {12'd0, ev_s1.act_ch};
		if (ev_s1.close) begin
			acc_n.bsum = acc_b.bsum + {10'd0, ev_s1.b};
			if (ev_s1.act_node) begin
				acc_n.act_nodes = acc_b.act_nodes + 11'd1;
				acc_n.wsum      = acc_b.wsum + {9'd0, prod};
				acc_n.wtsum     = acc_b.wtsum + {10'd0, ev_s1.b};
				if (run_b == '0) begin
					acc_n.runs = acc_b.runs + 10'd1;
				end
				run_n = run_b + 11'd1;
				if (run_n > acc_b.longest) begin
					acc_n.longest = run_n;
				end
			end else begin
				run_n = '0;
			end
			if (ev_s1.cmp) begin
				acc_n.chg = acc_b.chg + {10'd0, diff};
			end
		end

		res_n     = acc_n;
		res_n.chg = ev_s1.chg_valid ? acc_n.chg : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				if (ev_s1.last) begin
					acc_q <= '0;
					run_q <= '0;
				end else begin
					acc_q <= acc_n;
					run_q <= run_n;
				end
			end
			if (s1_go && ev_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ev_s1 <= ev;
		end
		if (s1_go && ev_s1.last) begin
			out_q    <= res_n;
			out_cv_q <= ev_s1.chg_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_cv_q;
	assign m_tdata  = {1'b0, out_q.chg, out_q.wtsum, out_q.wsum, out_q.longest, out_q.runs,
		out_q.bsum, out_q.lmax, out_q.lsum, out_q.act_nodes, out_q.act_ch};

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(ev_s1))
		else $error("stalled beat in accumulate stage lost");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q.longest >= run_q)
		else $error("current run exceeds longest run");
`endif

endmodule

[rtl/light_frame_activity_stats_unit.sv]
// Lighting frame activity statistics.
// Input stream: one channel byte per beat, s_tdata[7:0] = level, s_tuser[0] =
// new_window (first byte of a window: restart the frame, drop history).
// A frame is channel_count bytes; the beat that ends it yields one result beat on
// the output stream, with all statistics in m_tdata and change_valid in m_tuser.
// Configuration: cfg_index 0..3 selects channel_count, node_count,
// channels_per_node, active_threshold; cfg_ready is always high.
// Throughput: one byte per cycle while s_tready is high. From the beat that ends a
// frame to its result beat, the accumulate stage registers the byte and reads the
// previous-frame brightness memory, then the output register takes the result.
// Stall: the output register holds a result until taken; the next frame's
// result waits in the accumulate stage, and only then does s_tready drop.
// Reset: counters, accumulators and history clear at once and the registers
// take 1, 1, 1, 8; the brightness memory is not cleared, as its entries are
// read only after the preceding frame has written them.
module light_frame_activity_stats_unit #(
	parameter int MAX_CHANNELS = 4096,
	parameter int MAX_NODES    = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // level[7:0]
	input  logic [0:0]                      s_tuser,  // new_window[0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// active_channels[12:0], active_nodes[23:13], level_sum[43:24],
	// max_level[51:44], brightness_sum[70:52], run_count[80:71],
	// longest_run[91:81], weighted_sum[120:92], weight_sum[139:121],
	// change_sum[158:140], zero[159]
	output logic [lfas_pkg::TDATA_W-1:0]    m_tdata,
	output logic [0:0]                      m_tuser,  // change_valid[0]
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfas_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NCAP = (MAX_NODES < lfas_pkg::NODE_REG_MAX) ? MAX_NODES
		: lfas_pkg::NODE_REG_MAX;
	localparam int AW = (NCAP > 1) ? $clog2(NCAP) : 1;

	lfas_pkg::cfg_t                cfg_q;
	lfas_pkg::ev_t                 ev;
	logic                          accept;
	logic                          s1_ready;
	logic [lfas_pkg::BRIGHT_W-1:0] prev_b, wr_data;
	logic [AW-1:0]                 wr_addr;
	logic                          wr_en;

	assign cfg_ready = 1'b1;
	assign s_tready  = s1_ready;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count     <= 13'd1;
			cfg_q.node_count        <= 11'd1;
			cfg_q.channels_per_node <= 13'd1;
			cfg_q.active_threshold  <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfas_pkg::REG_CHANNEL_COUNT: begin
					cfg_q.channel_count <= cfg_data[12:0];
				end
				lfas_pkg::REG_NODE_COUNT: begin
					cfg_q.node_count <= cfg_data[10:0];
				end
				lfas_pkg::REG_CHANNELS_PER_NODE: begin
					cfg_q.channels_per_node <= cfg_data[12:0];
				end
				lfas_pkg::REG_ACTIVE_THRESHOLD: begin
					cfg_q.active_threshold <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	lfas_node #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_NODES   (MAX_NODES)
	) u_node (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.level     (s_tdata),
		.new_window(s_tuser[0]),
		.cfg       (cfg_q),
		.ev        (ev)
	);

	lfas_prev_mem #(
		.DEPTH(NCAP),
		.AW   (AW)
	) u_prev_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(ev.idx[AW-1:0]),
		.rd_data(prev_b),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lfas_frame_acc #(
		.AW(AW)
	) u_frame_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(accept),
		.ev       (ev),
		.s1_ready (s1_ready),
		.prev_b   (prev_b),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
